@@ design/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, types and state codes of the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int EXP_WIDTH = 32;
  localparam int MOD_WIDTH = 31;
  localparam int BASE_W    = 31;
  localparam int OUT_W     = 31;
  localparam int CFG_W     = 31;

  // exponent register holds either the given exponent or modulus - 2
  localparam int E_W   = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
  // multiplier bits walked by the serial unit
  localparam int OPB_W = (BASE_W > MOD_WIDTH) ? BASE_W : MOD_WIDTH;
  localparam int CNT_W = $clog2(OPB_W);

  localparam logic [CFG_W-1:0] MOD_RESET = CFG_W'(1000000007);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_DONE
  } mexp_state_t;

  typedef struct packed {
    logic                 start;
    logic [MOD_WIDTH-1:0] a;
    logic [OPB_W-1:0]     b;
  } mexp_op_t;

  typedef struct packed {
    logic                 done;
    logic [MOD_WIDTH-1:0] prod;
  } mexp_stat_t;

endpackage

@@ design/mexp_mulmod.sv @@
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial modular multiplier: a * b mod m, one multiplier bit per cycle,
// most significant first, with the running remainder kept below m.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic                         clk,
  input  logic                         rst,
  input  mexp_pkg::mexp_op_t           op,
  input  logic [mexp_pkg::MOD_WIDTH:0] modv,
  output mexp_pkg::mexp_stat_t         stat
);

  localparam int T_W = mexp_pkg::MOD_WIDTH + 3;

  logic [mexp_pkg::MOD_WIDTH-1:0] r;
  logic [mexp_pkg::MOD_WIDTH-1:0] a;
  logic [mexp_pkg::OPB_W-1:0]     bsh;
  logic [mexp_pkg::CNT_W-1:0]     cnt;
  logic                           done_q;

  logic [mexp_pkg::MOD_WIDTH-1:0] r_src;
  logic [mexp_pkg::MOD_WIDTH-1:0] a_src;
  logic                           bit_in;
  logic [T_W-1:0]                 t;
  logic [T_W-1:0]                 d1;
  logic [T_W-1:0]                 d2;
  logic [T_W-1:0]                 r_step;
  logic [mexp_pkg::MOD_WIDTH-1:0] r_next;

  // the first step is taken in the cycle the operation is issued
  always_comb begin
    r_src  = op.start ? '0 : r;
    a_src  = op.start ? op.a : a;
    bit_in = op.start ? op.b[mexp_pkg::OPB_W-1] : bsh[mexp_pkg::OPB_W-1];
    t      = T_W'({r_src, 1'b0}) + T_W'(bit_in ? a_src : '0);
    // t stays below 3m, so at most two subtractions of m
    d1     = t - T_W'(modv);
    d2     = t - T_W'({modv, 1'b0});
    if (!d2[T_W-1]) begin
      r_step = d2;
    end else if (!d1[T_W-1]) begin
      r_step = d1;
    end else begin
      r_step = t;
    end
    r_next = r_step[mexp_pkg::MOD_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt == mexp_pkg::CNT_W'(1));
      if (op.start) begin
        cnt <= mexp_pkg::CNT_W'(mexp_pkg::OPB_W - 1);
      end else if (cnt != '0) begin
        cnt <= cnt - mexp_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op.start) begin
      r   <= r_next;
      a   <= op.a;
      bsh <= op.b << 1;
    end else if (cnt != '0) begin
      r   <= r_next;
      bsh <= bsh << 1;
    end
  end

  assign stat.done = done_q;
  assign stat.prod = r;

endmodule

@@ design/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply of base^exponent mod modulus on one
// shared bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// A serial multiply (one multiplier bit per cycle) first reduces the base, then
// one multiply per set exponent bit and one square per bit below the top
// follow; a zero effective exponent goes straight to done with no multiply.
// One item at a time; the next is taken the cycle after done. Synchronous rst
// sets the modulus register to 1000000007 and the controller to idle.
module modular_exponentiation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          mode,
  input  logic [mexp_pkg::BASE_W-1:0]   base,
  input  logic [mexp_pkg::EXP_WIDTH-1:0] exponent,
  input  logic                          cfg_write,
  input  logic [mexp_pkg::CFG_W-1:0]    cfg_data,
  output logic                          done,
  output logic [mexp_pkg::OUT_W-1:0]    power_result
);

  mexp_pkg::mexp_state_t          state;
  mexp_pkg::mexp_state_t          state_next;
  logic [mexp_pkg::MOD_WIDTH-1:0] modulus;
  logic [mexp_pkg::E_W-1:0]       e;
  logic [mexp_pkg::MOD_WIDTH-1:0] acc;
  logic [mexp_pkg::MOD_WIDTH-1:0] p;

  logic [mexp_pkg::MOD_WIDTH:0]   mod_ext;
  logic [mexp_pkg::E_W-1:0]       eff_e;
  logic                           e_hi_nz;
  mexp_pkg::mexp_op_t             op;
  mexp_pkg::mexp_stat_t           u_stat;

  // a modulus of zero means reduction modulo 2^MOD_WIDTH
  assign mod_ext = {modulus == '0, modulus};
  assign e_hi_nz = |e[mexp_pkg::E_W-1:1];

  always_comb begin
    if (mode) begin
      eff_e = (modulus > mexp_pkg::MOD_WIDTH'(2)) ?
              mexp_pkg::E_W'(modulus - mexp_pkg::MOD_WIDTH'(2)) : '0;
    end else begin
      eff_e = mexp_pkg::E_W'(exponent);
    end
  end

  mexp_mulmod u_mulmod (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .modv (mod_ext),
    .stat (u_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mexp_pkg::S_IDLE: begin
        if (start) begin
          state_next = (eff_e == '0) ? mexp_pkg::S_DONE : mexp_pkg::S_REDUCE;
        end
      end
      mexp_pkg::S_REDUCE: begin
        if (u_stat.done) begin
          state_next = e[0] ? mexp_pkg::S_MUL : mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_MUL: begin
        if (u_stat.done) begin
          state_next = e_hi_nz ? mexp_pkg::S_SQR : mexp_pkg::S_DONE;
        end
      end
      mexp_pkg::S_SQR: begin
        // e[1] is the bit that becomes current after this square
        if (u_stat.done) begin
          state_next = e[1] ? mexp_pkg::S_MUL : mexp_pkg::S_SQR;
        end
      end
      mexp_pkg::S_DONE: begin
        state_next = mexp_pkg::S_IDLE;
      end
      default: begin
        state_next = mexp_pkg::S_IDLE;
      end
    endcase
  end

  // outputs and multiplier issue
  always_comb begin
    op    = '0;
    busy  = 1'b1;
    done  = 1'b0;
    case (state)
      mexp_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start && (eff_e != '0)) begin
          // base mod m, as 1 * base
          op.start = 1'b1;
          op.a     = mexp_pkg::MOD_WIDTH'(1);
          op.b     = mexp_pkg::OPB_W'(base);
        end
      end
      mexp_pkg::S_REDUCE: begin
        if (u_stat.done) begin
          op.start = 1'b1;
          op.a     = e[0] ? acc : u_stat.prod;
          op.b     = mexp_pkg::OPB_W'(u_stat.prod);
        end
      end
      mexp_pkg::S_MUL: begin
        if (u_stat.done && e_hi_nz) begin
          op.start = 1'b1;
          op.a     = p;
          op.b     = mexp_pkg::OPB_W'(p);
        end
      end
      mexp_pkg::S_SQR: begin
        if (u_stat.done) begin
          op.start = 1'b1;
          op.a     = e[1] ? acc : u_stat.prod;
          op.b     = mexp_pkg::OPB_W'(u_stat.prod);
        end
      end
      mexp_pkg::S_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  assign power_result = mexp_pkg::OUT_W'(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mexp_pkg::S_IDLE;
      modulus <= mexp_pkg::MOD_WIDTH'(mexp_pkg::MOD_RESET);
    end else begin
      state <= state_next;
      if (cfg_write) begin
        modulus <= mexp_pkg::MOD_WIDTH'(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      mexp_pkg::S_IDLE: begin
        if (start) begin
          e   <= eff_e;
          acc <= mexp_pkg::MOD_WIDTH'(1);
        end
      end
      mexp_pkg::S_REDUCE: begin
        if (u_stat.done) begin
          p <= u_stat.prod;
        end
      end
      mexp_pkg::S_MUL: begin
        if (u_stat.done) begin
          acc <= u_stat.prod;
        end
      end
      mexp_pkg::S_SQR: begin
        if (u_stat.done) begin
          p <= u_stat.prod;
          e <= e >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_unit_done_in_op: assert property (@(posedge clk) disable iff (rst)
    u_stat.done |-> (state == mexp_pkg::S_REDUCE || state == mexp_pkg::S_MUL ||
                     state == mexp_pkg::S_SQR))
    else $error("multiplier finished outside an operation");

  a_exp_live: assert property (@(posedge clk) disable iff (rst)
    (state == mexp_pkg::S_REDUCE || state == mexp_pkg::S_MUL ||
     state == mexp_pkg::S_SQR) |-> (e != '0))
    else $error("exponent ran out during an operation");

  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> ((mexp_pkg::MOD_WIDTH'(1) == acc) || ({1'b0, acc} < mod_ext)))
    else $error("result not below modulus");

endmodule

@@ test/modular_exponentiation_tb.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_tb
// Self-checking bench for the modular exponentiation block: directed corner
// items, then random items over several modulus settings, each result
// checked against a square-and-multiply predictor kept in the bench.
// ----------------------------------------------------------------------------
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  RESET_CYCLES = 6;
  localparam int  SETTLE_CYCLES = 4;
  localparam int  TAIL_CYCLES = 2048;
  localparam int  WATCHDOG_LIMIT = 10000;
  localparam int  PHASES = 9;
  localparam int  ITEMS_PER_PHASE = 30;
  localparam logic MODE_POWER = 1'b0;
  localparam logic MODE_INVERSE = 1'b1;
  localparam logic [mexp_pkg::CFG_W-1:0] MOD_MAX = {mexp_pkg::CFG_W{1'b1}};

  typedef enum logic [1:0] {
    ENT_ITEM,
    ENT_CFG,
    ENT_DRAIN
  } request_kind_t;

  typedef enum logic [1:0] {
    DRV_FETCH,
    DRV_GAP,
    DRV_SEND,
    DRV_DRAIN
  } driver_state_t;

  typedef struct {
    request_kind_t                  kind;
    logic                           mode;
    logic [mexp_pkg::BASE_W-1:0]    base;
    logic [mexp_pkg::EXP_WIDTH-1:0] exponent;
    int                             gap;
    logic                           gap_when_idle;
    logic [mexp_pkg::CFG_W-1:0]     modulus;
  } request_t;

  typedef struct {
    logic                           mode;
    logic [mexp_pkg::BASE_W-1:0]    base;
    logic [mexp_pkg::EXP_WIDTH-1:0] exponent;
    logic [mexp_pkg::CFG_W-1:0]     modulus;
    logic [mexp_pkg::OUT_W-1:0]     power;
  } power_rec_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           start = 1'b0;
  logic                           busy;
  logic                           mode = 1'b0;
  logic [mexp_pkg::BASE_W-1:0]    base = '0;
  logic [mexp_pkg::EXP_WIDTH-1:0] exponent = '0;
  logic                           cfg_write = 1'b0;
  logic [mexp_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           done;
  logic [mexp_pkg::OUT_W-1:0]     power_result;

  request_t                   queued_requests[$];
  power_rec_t                 expected_powers[$];
  request_t                   cur;
  driver_state_t              drv_state = DRV_FETCH;
  logic [mexp_pkg::CFG_W-1:0] cur_modulus = mexp_pkg::MOD_RESET;
  int                         wait_left = 0;
  int                         settle_left = 0;
  logic                       stim_done = 1'b0;
  logic                       timed_out = 1'b0;
  logic                       no_idle = 1'b0;
  int                         idle_cycles = 0;
  int                         items_sent = 0;
  int                         results_seen = 0;
  int                         modulus_writes = 0;
  int                         err_count = 0;

  modular_exponentiation DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .base(base),
    .exponent(exponent),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .done(done),
    .power_result(power_result)
  );

  always #4 clk = ~clk;

  // modulus zero keeps the low bits instead of dividing
  function automatic logic [63:0] reduce_mod(logic [63:0] x,
                                             logic [mexp_pkg::CFG_W-1:0] m);
    if (m == '0) return x & ((64'd1 << mexp_pkg::MOD_WIDTH) - 64'd1);
    return x % 64'(m);
  endfunction

  function automatic logic [mexp_pkg::OUT_W-1:0] modpow(
      logic md, logic [mexp_pkg::BASE_W-1:0] b,
      logic [mexp_pkg::EXP_WIDTH-1:0] x,
      logic [mexp_pkg::CFG_W-1:0] m);
    logic [63:0] e;
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq = 64'(b);
    if (md == MODE_INVERSE) begin
      e = (m > 2) ? 64'(m) - 64'd2 : 64'd0;
    end else begin
      e = 64'(x);
    end
    // right to left over the exponent bits
    while (e != 0) begin
      if (e[0]) acc = reduce_mod(acc * sq, m);
      sq = reduce_mod(sq * sq, m);
      e = e >> 1;
    end
    return acc[mexp_pkg::OUT_W-1:0];
  endfunction

  task automatic add_item(input logic md, input logic [mexp_pkg::BASE_W-1:0] b,
                          input logic [mexp_pkg::EXP_WIDTH-1:0] x);
    request_t r;
    r.kind = ENT_ITEM;
    r.mode = md;
    r.base = b;
    r.exponent = x;
    r.gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
    r.gap_when_idle = $urandom_range(0, 1);
    r.modulus = '0;
    queued_requests = {queued_requests, r};
  endtask

  task automatic add_control(input request_kind_t k,
                             input logic [mexp_pkg::CFG_W-1:0] m);
    request_t r;
    r.kind = k;
    r.mode = MODE_POWER;
    r.base = '0;
    r.exponent = '0;
    r.gap = 0;
    r.gap_when_idle = 1'b0;
    r.modulus = m;
    queued_requests = {queued_requests, r};
  endtask

  task automatic add_random_item();
    logic [mexp_pkg::BASE_W-1:0]    b;
    logic [mexp_pkg::EXP_WIDTH-1:0] x;
    int                             w;
    case ($urandom_range(0, 7))
      0: b = '0;
      1: b = {mexp_pkg::BASE_W{1'b1}};
      2: b = mexp_pkg::BASE_W'($urandom_range(0, 15));
      default: b = mexp_pkg::BASE_W'($urandom);
    endcase
    // mostly short exponents keep the run time down
    case ($urandom_range(0, 9))
      0: x = '0;
      1, 2: x = $urandom;
      3: x = {mexp_pkg::EXP_WIDTH{1'b1}};
      default: begin
        w = $urandom_range(1, 12);
        x = $urandom & ((32'd1 << w) - 32'd1);
      end
    endcase
    add_item(($urandom_range(0, 4) == 0) ? MODE_INVERSE : MODE_POWER, b, x);
  endtask

  function automatic logic [mexp_pkg::CFG_W-1:0] random_modulus();
    case ($urandom_range(0, 7))
      0: return mexp_pkg::CFG_W'($urandom_range(3, 64));
      1: return mexp_pkg::CFG_W'(998244353);
      2: return mexp_pkg::CFG_W'(65521);
      3: return mexp_pkg::CFG_W'($urandom_range(1, 65535));
      default: return mexp_pkg::CFG_W'($urandom);
    endcase
  endfunction

  // driver: one nonblocking write per signal per edge
  always @(posedge clk) begin : driver
    logic       nxt_start;
    logic       nxt_write;
    power_rec_t rec;
    nxt_start = start;
    nxt_write = 1'b0;
    if (rst) begin
      nxt_start = 1'b0;
      drv_state = DRV_FETCH;
      cur_modulus = mexp_pkg::MOD_RESET;
    end else begin
      if (start && !busy) begin
        rec.mode = cur.mode;
        rec.base = cur.base;
        rec.exponent = cur.exponent;
        rec.modulus = cur_modulus;
        rec.power = modpow(cur.mode, cur.base, cur.exponent, cur_modulus);
        expected_powers = {expected_powers, rec};
        items_sent++;
        nxt_start = 1'b0;
        drv_state = DRV_FETCH;
      end
      if (drv_state == DRV_FETCH) begin
        if (queued_requests.size() == 0) begin
          stim_done <= 1'b1;
        end else begin
          cur = queued_requests.pop_front();
          wait_left = cur.gap;
          settle_left = SETTLE_CYCLES;
          drv_state = (cur.kind == ENT_ITEM) ? DRV_GAP : DRV_DRAIN;
        end
      end
      if (drv_state == DRV_GAP) begin
        if (cur.gap_when_idle && busy) begin
          // hold the gap until the block is free
        end else if (wait_left != 0) begin
          wait_left--;
        end else begin
          mode <= cur.mode;
          base <= cur.base;
          exponent <= cur.exponent;
          nxt_start = 1'b1;
          drv_state = DRV_SEND;
        end
      end
      if (drv_state == DRV_DRAIN) begin
        if (expected_powers.size() != 0 || busy) begin
          settle_left = SETTLE_CYCLES;
        end else if (settle_left != 0) begin
          settle_left--;
        end else begin
          if (cur.kind == ENT_CFG) begin
            nxt_write = 1'b1;
            cfg_data <= cur.modulus;
            cur_modulus = cur.modulus;
            modulus_writes++;
          end
          drv_state = DRV_FETCH;
        end
      end
    end
    start <= nxt_start;
    cfg_write <= nxt_write;
  end

  always @(posedge clk) begin : monitor
    power_rec_t want;
    if (!rst && done) begin
      results_seen++;
      if (expected_powers.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual power_result %0d",
                 $time, power_result);
      end else begin
        want = expected_powers.pop_front();
        if (power_result !== want.power) begin
          err_count++;
          $display("%0t: power_result mismatch, expected %0d actual %0d",
                   $time, want.power, power_result);
          $display("  mode %0d base %0d exponent %0d modulus %0d",
                   want.mode, want.base, want.exponent, want.modulus);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out <= 1'b1;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int phase;
    int i;

    // directed items, first at the reset modulus, then at moduli 1, 2, 0, 2^31-1 and 3
    add_item(MODE_POWER, '0, '0);
    add_item(MODE_POWER, '0, 32'd1);
    add_item(MODE_POWER, {mexp_pkg::BASE_W{1'b1}}, {mexp_pkg::EXP_WIDTH{1'b1}});
    add_item(MODE_POWER, 31'd2, 32'h8000_0000);
    add_item(MODE_POWER, 31'd3, 32'd1);
    add_item(MODE_INVERSE, 31'd12345, 32'd0);
    add_item(MODE_INVERSE, {mexp_pkg::BASE_W{1'b1}}, {mexp_pkg::EXP_WIDTH{1'b1}});
    // base at or above the modulus, never pre-reduced
    add_item(MODE_POWER, mexp_pkg::BASE_W'(mexp_pkg::MOD_RESET), 32'd5);
    add_item(MODE_POWER, mexp_pkg::BASE_W'(mexp_pkg::MOD_RESET) + 31'd9, 32'd1);
    add_control(ENT_CFG, mexp_pkg::CFG_W'(1));
    add_item(MODE_POWER, 31'd5, 32'd0);
    add_item(MODE_POWER, 31'd5, 32'd3);
    add_item(MODE_INVERSE, 31'd5, 32'd0);
    add_control(ENT_CFG, mexp_pkg::CFG_W'(2));
    add_item(MODE_INVERSE, 31'd3, 32'd0);
    add_item(MODE_POWER, 31'd3, 32'd7);
    // modulus zero wraps at the register width
    add_control(ENT_CFG, '0);
    add_item(MODE_POWER, {mexp_pkg::BASE_W{1'b1}}, 32'd2);
    add_item(MODE_INVERSE, 31'd7, 32'd9);
    add_item(MODE_POWER, 31'd3, 32'd40);
    add_control(ENT_CFG, MOD_MAX);
    add_item(MODE_INVERSE, 31'd7, 32'd0);
    add_item(MODE_POWER, {mexp_pkg::BASE_W{1'b1}}, {mexp_pkg::EXP_WIDTH{1'b1}});
    add_control(ENT_CFG, mexp_pkg::CFG_W'(3));
    add_item(MODE_INVERSE, 31'd2, 32'd0);

    for (phase = 0; phase < PHASES; phase++) begin
      no_idle = (phase % 3 == 0);
      add_control(ENT_CFG, random_modulus());
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // let the block run dry now and then
        if ((phase == 4 && i == ITEMS_PER_PHASE / 2) || $urandom_range(0, 39) == 0) begin
          add_control(ENT_DRAIN, '0);
        end
        add_random_item();
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (!((stim_done && expected_powers.size() == 0) || timed_out)) @(posedge clk);
    if (timed_out) begin
      $display("%0t: watchdog expired, %0d items still expected",
               $time, expected_powers.size());
      $display("Some tests failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      $display("covered %0d items and %0d results over %0d modulus writes",
               items_sent, results_seen, modulus_writes);
      $display("modulus 0, 1, 2, 3 and 2^31-1 exercised with power and inverse modes");
      if (err_count == 0 && expected_powers.size() == 0) begin
        $display("All tests passed");
      end else begin
        $display("Some tests failed");
      end
      $finish;
    end
  end

endmodule
